/* hw/rtl/psnt_pkg.sv */
`default_nettype none

package psnt_pkg;

  // Field widths of the item channels
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned SEQ_W  = 2;

  // Default number of peer slots in each table
  localparam int unsigned PEER_SLOTS_DEF = 16;

  // Command codes; the codes above CMD_TX_PEEK are unused
  typedef enum logic [CMD_W-1:0] {
    CMD_RX_FETCH = 3'd0,
    CMD_RX_SET   = 3'd1,
    CMD_TX_FETCH = 3'd2,
    CMD_RX_PEEK  = 3'd3,
    CMD_TX_PEEK  = 3'd4
  } cmd_e;

  // Sequence number given to a peer newly entered by a fetch
  localparam logic [SEQ_W-1:0] SEQ_RX_NEW = 2'd0;
  localparam logic [SEQ_W-1:0] SEQ_TX_NEW = 2'd1;

  // One table slot: peer address (an empty slot reads as zero) and its sequence number
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

endpackage

`default_nettype wire

/* hw/rtl/psnt_in_if.sv */
`default_nettype none

interface psnt_in_if;
  import psnt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] node_address;
  logic [SEQ_W-1:0]  new_sequence;

  modport source (output valid, command, node_address, new_sequence, input ready);
  modport sink (input valid, command, node_address, new_sequence, output ready);

endinterface

`default_nettype wire

/* hw/rtl/psnt_out_if.sv */
`default_nettype none

interface psnt_out_if;
  import psnt_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] sequence_res;
  logic             table_full;

  modport source (output valid, sequence_res, table_full, input ready);
  modport sink (input valid, sequence_res, table_full, output ready);

endinterface

`default_nettype wire

/* hw/rtl/psnt_ram.sv */
`default_nettype none

module psnt_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/peer_sequence_number_table.sv */
`default_nettype none

// Per-peer sequence number table. Two tables, receive and transmit, each hold
// PeerSlots slots of {peer address, 2-bit sequence number} in a RAM with one
// write port and one read port with registered read. An item is
// accepted only when the block is idle; the block then walks the selected
// table from slot 0, one slot per cycle, until it finds the peer, the first
// empty slot, or the last slot; an unused command ends the scan at once. The
// result is decided and the table written back in that last scan cycle, once
// the output register is free to take it; the next item can then be accepted
// in the same cycle as that result appears. The result sits in an output
// register and the next item is taken while it waits.
// Occupied slots always form a prefix of the table, so a fill count per table
// stands in for clearing the RAM: the block is ready right out of reset. A
// fetch or set that needs a new slot in a full table changes nothing and
// returns table_full set.
module peer_sequence_number_table #(
  parameter int unsigned PeerSlots = psnt_pkg::PEER_SLOTS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psnt_in_if.sink     in_i,
  psnt_out_if.source  out_o
);
  import psnt_pkg::*;

  localparam int unsigned IdxW  = (PeerSlots > 1) ? $clog2(PeerSlots) : 1;
  localparam int unsigned FillW = $clog2(PeerSlots + 1);
  localparam logic [IdxW-1:0]  IdxLast  = IdxW'(PeerSlots - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(PeerSlots);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q;
  logic [ADDR_W-1:0]  peer_q;
  logic [SEQ_W-1:0]   nseq_q;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [FillW-1:0]   rx_fill_q, tx_fill_q;
  logic               rx_zseq_q, tx_zseq_q;
  logic               out_valid_q;
  logic [SEQ_W-1:0]   res_q;
  logic               full_q;

  ent_t               rx_rdata, tx_rdata, rd, wdata;
  logic               tx_sel, bad_cmd, occupied, hit, done, out_free, decide;
  logic               we, full, zseq_sel;
  logic [FillW-1:0]   fill_sel;
  logic [ADDR_W-1:0]  eff_addr;
  logic [SEQ_W-1:0]   eff_seq, res;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.sequence_res = res_q;
  assign out_o.table_full   = full_q;

  // Select the table the command works on
  assign tx_sel  = (cmd_q == CMD_TX_FETCH) || (cmd_q == CMD_TX_PEEK);
  assign bad_cmd = (cmd_q > CMD_TX_PEEK);
  assign rd       = tx_sel ? tx_rdata : rx_rdata;
  assign fill_sel = tx_sel ? tx_fill_q : rx_fill_q;
  assign zseq_sel = tx_sel ? tx_zseq_q : rx_zseq_q;

  // Mask slots past the fill count; the first empty slot keeps a number
  // only once an address-zero item has written it
  assign occupied = (FillW'(idx_q) < fill_sel);
  assign eff_addr = occupied ? rd.addr : '0;
  assign eff_seq  = (occupied || zseq_sel) ? rd.seq : '0;

  // End the scan on a match, on the first empty slot, on the last slot or on an unused command
  assign hit      = (eff_addr == peer_q);
  assign done     = hit || !occupied || (idx_q == IdxLast) || bad_cmd;
  assign out_free = !out_valid_q || out_o.ready;
  assign decide   = (state_q == ST_SCAN) && done && out_free;

  // Work out the result and the write-back for the slot under the scan
  always_comb begin
    we    = 1'b0;
    wdata = '{addr: peer_q, seq: nseq_q};
    res   = '0;
    full  = 1'b0;
    case (cmd_q)
      CMD_RX_FETCH: begin
        if (hit) begin
          res = eff_seq;
        end else if (!occupied) begin
          we         = 1'b1;
          wdata.seq  = SEQ_RX_NEW;
        end else begin
          full = 1'b1;
        end
      end
      CMD_RX_SET: begin
        if (hit || !occupied) begin
          we = 1'b1;
        end else begin
          full = 1'b1;
        end
      end
      CMD_TX_FETCH: begin
        if (hit) begin
          res       = eff_seq;
          we        = 1'b1;
          wdata.seq = eff_seq + SEQ_W'(1);
        end else if (!occupied) begin
          we        = 1'b1;
          wdata.seq = SEQ_TX_NEW;
        end else begin
          full = 1'b1;
        end
      end
      CMD_RX_PEEK, CMD_TX_PEEK: begin
        if (hit) begin
          res = eff_seq;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the scan address; the RAM reads the slot for the next cycle
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (decide) begin
          state_d = ST_IDLE;
          idx_d   = '0;
        end else if (!done) begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  psnt_ram #(
    .Width (ENT_W),
    .Depth (PeerSlots)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (decide && we && !tx_sel),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (1'b1),
    .raddr_i (idx_d),
    .rdata_o (rx_rdata)
  );

  psnt_ram #(
    .Width (ENT_W),
    .Depth (PeerSlots)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (decide && we && tx_sel),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (1'b1),
    .raddr_i (idx_d),
    .rdata_o (tx_rdata)
  );

  // Hold state, fill counts and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rx_fill_q   <= '0;
      tx_fill_q   <= '0;
      rx_zseq_q   <= 1'b0;
      tx_zseq_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (decide && we) begin
        if (!hit) begin
          // new peer takes the first empty slot
          if (tx_sel) begin
            tx_fill_q <= tx_fill_q + FillW'(1);
            tx_zseq_q <= 1'b0;
          end else begin
            rx_fill_q <= rx_fill_q + FillW'(1);
            rx_zseq_q <= 1'b0;
          end
        end else if (!occupied) begin
          // address zero wrote the number of the first empty slot
          if (tx_sel) begin
            tx_zseq_q <= 1'b1;
          end else begin
            rx_zseq_q <= 1'b1;
          end
        end
      end
      if (decide) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.command;
      peer_q <= in_i.node_address;
      nseq_q <= in_i.new_sequence;
    end
    if (decide) begin
      res_q  <= res;
      full_q <= full;
    end
  end

  // Fill counts never pass the table depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fill_q <= FillFull) && (tx_fill_q <= FillFull))
    else $error("fill count beyond table depth");

  // A full flag is only reported when the chosen table is at capacity
  a_full_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && full) |-> (fill_sel == FillFull))
    else $error("table_full with free slots");

  // Entering a new receive peer grows the receive fill count by one
  a_rx_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide && we && !hit && !tx_sel) |=> (rx_fill_q == $past(rx_fill_q) + FillW'(1)))
    else $error("receive fill count did not advance");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import psnt_pkg::*;

  localparam int PEER_SLOTS   = PEER_SLOTS_DEF;
  localparam int TBL_RX       = 0;
  localparam int TBL_TX       = 1;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = PEER_SLOTS + 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int FILL_PEERS   = PEER_SLOTS + 4;

  // Codes past the last defined command do nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_W'(CMD_TX_PEEK + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;

  // Peers entered by the fill test, and addressed again later
  localparam logic [ADDR_W-1:0] FILL_BASE = 8'h40;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             full;
  } seq_result_t;

  logic clk;
  logic rst_n;

  psnt_in_if  in_if ();
  psnt_out_if out_if ();

  peer_sequence_number_table dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow copy of both tables, index 0 receive, index 1 transmit
  logic [ADDR_W-1:0] peer_addr [2][PEER_SLOTS];
  logic [SEQ_W-1:0]  peer_seq  [2][PEER_SLOTS];

  seq_result_t pending_results[$];

  int error_count  = 0;
  int burst_left   = 0;
  int cycle_count  = 0;
  bit hold_request = 0;

  // Small set of peers that keeps the receive table short of full
  logic [ADDR_W-1:0] sparse_peers [12] = '{8'h01, 8'hFF, 8'h80, 8'h00, 8'h55, 8'hAA,
                                           8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h7E, 8'h81};

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Walk one table from slot 0 and apply the command to the shadow copy
  function automatic seq_result_t predict_result(input logic [CMD_W-1:0]  cmd,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [SEQ_W-1:0]  nseq);
    seq_result_t r;
    int tbl;
    int slot;
    bit hit;
    r = '0;
    if (cmd > CMD_TX_PEEK) return r;
    tbl  = (cmd == CMD_TX_FETCH || cmd == CMD_TX_PEEK) ? TBL_TX : TBL_RX;
    slot = PEER_SLOTS;
    hit  = 1'b0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      if (peer_addr[tbl][i] == addr) begin
        hit  = 1'b1;
        slot = i;
        break;
      end
      if (peer_addr[tbl][i] == '0) begin
        slot = i;
        break;
      end
    end
    case (cmd)
      CMD_RX_FETCH: begin
        if (hit) begin
          r.seq = peer_seq[tbl][slot];
        end else if (slot < PEER_SLOTS) begin
          peer_addr[tbl][slot] = addr;
          peer_seq[tbl][slot]  = SEQ_RX_NEW;
        end else begin
          r.full = 1'b1;
        end
      end
      CMD_RX_SET: begin
        if (slot < PEER_SLOTS) begin
          peer_addr[tbl][slot] = addr;
          peer_seq[tbl][slot]  = nseq;
        end else begin
          r.full = 1'b1;
        end
      end
      CMD_TX_FETCH: begin
        if (hit) begin
          r.seq = peer_seq[tbl][slot];
          peer_seq[tbl][slot] = peer_seq[tbl][slot] + 1'b1;
        end else if (slot < PEER_SLOTS) begin
          peer_addr[tbl][slot] = addr;
          peer_seq[tbl][slot]  = SEQ_TX_NEW;
        end else begin
          r.full = 1'b1;
        end
      end
      default: begin
        if (hit) r.seq = peer_seq[tbl][slot];
      end
    endcase
    return r;
  endfunction

  // Offer one item in bursts with random gaps; record its result once taken
  task automatic send_item(input logic [CMD_W-1:0]  cmd,
                           input logic [ADDR_W-1:0] addr,
                           input logic [SEQ_W-1:0]  nseq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.node_address <= addr;
    in_if.new_sequence <= nseq;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_result(cmd, addr, nseq));
    burst_left--;
  endtask

  function automatic logic [CMD_W-1:0] pick_command();
    if ($urandom_range(0, 15) == 0) begin
      return CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end
    return CMD_W'($urandom_range(CMD_RX_FETCH, CMD_TX_PEEK));
  endfunction

  // Dense mode mixes in the fill peers and fully random addresses
  function automatic logic [ADDR_W-1:0] pick_peer(input bit dense);
    int sel;
    sel = $urandom_range(0, 3);
    if (!dense || sel < 2) return sparse_peers[$urandom_range(0, 11)];
    if (sel == 2) return ADDR_W'(FILL_BASE + $urandom_range(0, FILL_PEERS - 1));
    return ADDR_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random_items(input int count, input bit dense);
    for (int i = 0; i < count; i++) begin
      send_item(pick_command(), pick_peer(dense), SEQ_W'($urandom_range(0, 3)));
    end
  endtask

  // Address zero on empty tables hits the first empty slot
  task automatic test_empty_table_zero_address();
    send_item(CMD_RX_PEEK, 8'h00, 2'd0);
    send_item(CMD_RX_SET, 8'h00, 2'd3);
    send_item(CMD_RX_PEEK, 8'h00, 2'd0);
    send_item(CMD_TX_FETCH, 8'h00, 2'd2);
    send_item(CMD_TX_PEEK, 8'h00, 2'd0);
  endtask

  task automatic test_rx_commands();
    send_item(CMD_RX_FETCH, 8'h01, 2'd3);
    send_item(CMD_RX_PEEK, 8'h01, 2'd0);
    send_item(CMD_RX_SET, 8'h01, 2'd2);
    send_item(CMD_RX_FETCH, 8'h01, 2'd0);
    send_item(CMD_RX_SET, 8'hFF, 2'd1);
    send_item(CMD_RX_PEEK, 8'hFF, 2'd0);
    send_item(CMD_RX_PEEK, 8'h80, 2'd3);
  endtask

  // Run one transmit peer through a full wrap of its number
  task automatic test_tx_wrap();
    repeat (5) send_item(CMD_TX_FETCH, 8'hFF, 2'd0);
    send_item(CMD_TX_PEEK, 8'hFF, 2'd0);
    send_item(CMD_TX_PEEK, 8'h80, 2'd0);
  endtask

  task automatic test_unused_commands();
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
      send_item(c[CMD_W-1:0], 8'hFF, 2'd3);
    end
  endtask

  // Enter more peers than slots in both tables, then probe the full tables
  task automatic test_fill_tables();
    for (int i = 0; i < FILL_PEERS; i++) begin
      send_item($urandom_range(0, 1) ? CMD_RX_SET : CMD_RX_FETCH,
                ADDR_W'(FILL_BASE + i), SEQ_W'($urandom_range(0, 3)));
      send_item(CMD_TX_FETCH, ADDR_W'(FILL_BASE + i), SEQ_W'($urandom_range(0, 3)));
    end
    send_item(CMD_RX_FETCH, 8'h00, 2'd0);
    send_item(CMD_RX_SET, 8'h00, 2'd2);
    send_item(CMD_TX_FETCH, 8'h00, 2'd0);
    send_item(CMD_RX_PEEK, 8'h00, 2'd0);
    send_item(CMD_TX_PEEK, 8'h00, 2'd0);
    send_item(CMD_RX_PEEK, 8'hE7, 2'd0);
    send_item(CMD_TX_PEEK, 8'hE7, 2'd0);
    send_item(CMD_RX_FETCH, 8'hE7, 2'd1);
    send_item(CMD_TX_FETCH, 8'hE7, 2'd1);
  endtask

  // Hold the output off long enough that the input stalls
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    burst_left   = 40;
    send_random_items(30, 1'b1);
  endtask

  // Accept and check results; stall on a pattern of its own
  initial begin
    int hold_left;
    int rx_mode;
    int rx_tick;
    seq_result_t exp_r;
    hold_left = 0;
    rx_mode   = 0;
    rx_tick   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result seq=%0d full=%0b", $time,
                   out_if.sequence_res, out_if.table_full);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_if.sequence_res !== exp_r.seq) begin
            $display("%0t: sequence_res expected %0d actual %0d", $time,
                     exp_r.seq, out_if.sequence_res);
            error_count++;
          end
          if (out_if.table_full !== exp_r.full) begin
            $display("%0t: table_full expected %0b actual %0b", $time,
                     exp_r.full, out_if.table_full);
            error_count++;
          end
        end
      end
      rx_tick++;
      if (rx_tick % 128 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          default: out_if.ready <= (rx_tick % 7) >= 3;
        endcase
      end
    end
  end

  // Reset, run each test in turn, drain and report
  initial begin
    // Start with both shadow tables empty
    foreach (peer_addr[t, s]) begin
      peer_addr[t][s] = '0;
      peer_seq[t][s]  = '0;
    end
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.command      <= CMD_RX_FETCH;
    in_if.node_address <= '0;
    in_if.new_sequence <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table_zero_address();
    test_rx_commands();
    test_tx_wrap();
    test_unused_commands();
    send_random_items(600, 1'b0);
    test_fill_tables();
    test_output_backpressure();
    send_random_items(1200, 1'b1);

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
